/* hw/rtl/rau_pkg.sv */
// Package with the command codes and shared types of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
  typedef enum logic [2:0] {
    CMD_REDUCE = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_SUB    = 3'd2,
    CMD_MUL    = 3'd3,
    CMD_DIV    = 3'd4,
    CMD_POW    = 3'd5
  } cmd_t;
  localparam int IO_WIDTH = 32;
  localparam int EXP_WIDTH = 6;
endpackage

/* hw/rtl/rau_if.sv */
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps
interface rau_req_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          command;
  logic signed [rau_pkg::IO_WIDTH-1:0] a_num;
  logic signed [rau_pkg::IO_WIDTH-1:0] a_den;
  logic signed [rau_pkg::IO_WIDTH-1:0] b_num;
  logic signed [rau_pkg::IO_WIDTH-1:0] b_den;
  logic signed [rau_pkg::EXP_WIDTH-1:0] exponent;
  modport source (output valid, command, a_num, a_den, b_num, b_den, exponent, input ready);
  modport sink (input valid, command, a_num, a_den, b_num, b_den, exponent, output ready);
endinterface

interface rau_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [rau_pkg::IO_WIDTH-1:0] res_num;
  logic signed [rau_pkg::IO_WIDTH-1:0] res_den;
  logic                                zero_by_zero;
  modport source (output valid, res_num, res_den, zero_by_zero, input ready);
  modport sink (input valid, res_num, res_den, zero_by_zero, output ready);
endinterface

/* hw/rtl/rational_arith_unit.sv */
// Top level of the rational arithmetic unit: sequencer, multiplier and reduction.
`timescale 1ns / 1ps
// The block takes one item at a time and is not ready while it works on it. A
// request runs through a small sequencer that shares one DATA_WIDTH multiplier
// (one product per cycle, registered) and one radix-2 divider. Reduction runs
// Euclid's algorithm by repeated modulo on the divider, then divides numerator
// and denominator by the GCD; at 32 bits the number of Euclid steps stays below
// about 46. Add and subtract take three products, multiply and divide two,
// before one reduction; power reduces the base and then runs up to MAX_POWER-1
// rounds of two products and one reduction. The result is held in an output
// register and the next item is taken once it has left. A result of 0/0 sets
// zero_by_zero with both result fields zero.
module rational_arith_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int MAX_POWER  = 31
) (
  input  logic   clk,
  input  logic   rst_n,
  rau_req_if.sink   in_req,
  rau_res_if.source out_res
);
  localparam int W  = DATA_WIDTH;
  localparam int IW = rau_pkg::IO_WIDTH;
  localparam int EW = rau_pkg::EXP_WIDTH;
  localparam int PW = $clog2(MAX_POWER + 1) > EW ? $clog2(MAX_POWER + 1) : EW;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MUL0  = 12'b000000000010,
    S_MUL1  = 12'b000000000100,
    S_MUL2  = 12'b000000001000,
    S_RSTART= 12'b000000010000,
    S_GCD   = 12'b000000100000,
    S_DIVN  = 12'b000001000000,
    S_DIVD  = 12'b000010000000,
    S_RFIN  = 12'b000100000000,
    S_POWNX = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]    cmd_r;
  logic [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic [PW-1:0] pw_r, pw_nxt;
  logic          negexp_r;
  logic [W-1:0]  rn_r, rn_nxt, rd_r, rd_nxt;   // fraction under reduction
  logic          rneg_r, rneg_nxt;
  logic [W-1:0]  ga_r, ga_nxt, gb_r, gb_nxt;   // Euclid pair
  logic [W-1:0]  tmp_r, tmp_nxt;
  logic          base_done_r, base_done_nxt;
  logic [W-1:0]  basen_r, basen_nxt, based_r, based_nxt;
  logic          zz_r, zz_nxt;
  logic [IW-1:0] on_r, on_nxt, od_r, od_nxt;
  logic          ov_r, ov_nxt;
  logic          div_issued_r, div_issued_nxt;

  // Shared multiplier.
  logic [W-1:0]   mul_a, mul_b, prod;
  logic [2*W-1:0] prod_full;
  assign prod_full = mul_a * mul_b;
  assign prod = prod_full[W-1:0];

  // Shared divider.
  logic         dv_start, dv_done;
  logic [W-1:0] dv_x, dv_y, dv_q, dv_rem;
  rau_divider #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_x), .divisor(dv_y),
    .done(dv_done), .quotient(dv_q), .remainder(dv_rem)
  );

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [W-1:0] from_io(input logic [IW-1:0] v);
    logic [IW+W-1:0] e;
    e = {{W{v[IW-1]}}, v};
    from_io = e[W-1:0];
  endfunction

  function automatic logic [IW-1:0] to_io(input logic [W-1:0] v);
    logic [IW+W-1:0] e;
    e = {{IW{v[W-1]}}, v};
    to_io = e[IW-1:0];
  endfunction

  logic [EW-1:0] e_mag;
  assign e_mag = in_req.exponent[EW-1] ? (~in_req.exponent + 1'b1) : in_req.exponent;
  assign in_req.ready = (state_r == S_IDLE) && !ov_r;

  always_comb begin
    state_nxt = state_r;
    pw_nxt = pw_r;
    rn_nxt = rn_r; rd_nxt = rd_r; rneg_nxt = rneg_r;
    ga_nxt = ga_r; gb_nxt = gb_r; tmp_nxt = tmp_r;
    base_done_nxt = base_done_r;
    basen_nxt = basen_r; based_nxt = based_r;
    zz_nxt = zz_r; on_nxt = on_r; od_nxt = od_r; ov_nxt = ov_r;
    div_issued_nxt = div_issued_r;
    mul_a = an_r; mul_b = bd_r;
    dv_start = 1'b0; dv_x = ga_r; dv_y = gb_r;
    if (ov_r && out_res.ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid && in_req.ready) begin
          base_done_nxt = 1'b0;
          if (e_mag == '0) pw_nxt = '0;
          else if (PW'(e_mag) > PW'(MAX_POWER)) pw_nxt = PW'(MAX_POWER);
          else pw_nxt = PW'(e_mag);
          unique case (in_req.command)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_MUL, rau_pkg::CMD_DIV:
              state_nxt = S_MUL0;
            default: begin
              rn_nxt = from_io(in_req.a_num);
              rd_nxt = from_io(in_req.a_den);
              state_nxt = S_RSTART;
            end
          endcase
        end
      end
      S_MUL0: begin
        // Denominator for add/sub/mul, swapped operand for divide.
        mul_a = ad_r;
        mul_b = (cmd_r == rau_pkg::CMD_DIV) ? bn_r : bd_r;
        rd_nxt = prod;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        mul_a = an_r;
        mul_b = (cmd_r == rau_pkg::CMD_DIV) ? bd_r :
                (cmd_r == rau_pkg::CMD_MUL) ? bn_r : bd_r;
        rn_nxt = prod;
        state_nxt = (cmd_r == rau_pkg::CMD_ADD || cmd_r == rau_pkg::CMD_SUB) ? S_MUL2 : S_RSTART;
      end
      S_MUL2: begin
        mul_a = ad_r;
        mul_b = (cmd_r == rau_pkg::CMD_SUB) ? (~bn_r + 1'b1) : bn_r;
        rn_nxt = rn_r + prod;
        state_nxt = S_RSTART;
      end
      S_RSTART: begin
        rneg_nxt = rn_r[W-1] ^ rd_r[W-1];
        rn_nxt = mag(rn_r);
        rd_nxt = mag(rd_r);
        ga_nxt = mag(rn_r);
        gb_nxt = mag(rd_r);
        div_issued_nxt = 1'b0;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        // Euclid: (a, b) <- (b, a mod b) until b is zero.
        if (gb_r == '0) begin
          if (ga_r == '0) begin
            zz_nxt = 1'b1;
            rn_nxt = '0;
            rd_nxt = '0;
            state_nxt = S_RFIN;
          end else begin
            dv_start = 1'b1; dv_x = rn_r; dv_y = ga_r;
            div_issued_nxt = 1'b1;
            zz_nxt = 1'b0;
            state_nxt = S_DIVN;
          end
        end else if (!div_issued_r) begin
          dv_start = 1'b1;
          div_issued_nxt = 1'b1;
        end else if (dv_done) begin
          ga_nxt = gb_r;
          gb_nxt = dv_rem;
          div_issued_nxt = 1'b0;
        end
      end
      S_DIVN: begin
        if (dv_done) begin
          rn_nxt = dv_q;
          dv_start = 1'b1; dv_x = rd_r; dv_y = ga_r;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (dv_done) begin
          rd_nxt = dv_q;
          rn_nxt = rneg_r ? (~rn_r + 1'b1) : rn_r;
          state_nxt = S_RFIN;
        end
      end
      S_RFIN: begin
        if (cmd_r != rau_pkg::CMD_POW || zz_r) begin
          state_nxt = S_FIN;
        end else if (!base_done_r) begin
          base_done_nxt = 1'b1;
          basen_nxt = rn_r;
          based_nxt = rd_r;
          if (pw_r == '0) begin
            rn_nxt = W'(1);
            rd_nxt = W'(1);
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_POWNX;
          end
        end else begin
          state_nxt = S_POWNX;
        end
      end
      S_POWNX: begin
        if (pw_r <= PW'(1)) begin
          if (negexp_r) begin
            if (rn_r[W-1]) begin
              rn_nxt = ~rd_r + 1'b1;
              rd_nxt = ~rn_r + 1'b1;
            end else begin
              rn_nxt = rd_r;
              rd_nxt = rn_r;
            end
          end
          state_nxt = S_FIN;
        end else begin
          // r = base * r: numerator product now, denominator next cycle.
          mul_a = basen_r; mul_b = rn_r;
          rn_nxt = prod;
          tmp_nxt = rd_r;
          pw_nxt = pw_r - 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Denominator product of a power round.
        mul_a = based_r; mul_b = tmp_r;
        rd_nxt = prod;
        state_nxt = S_RSTART;
      end
      S_FIN: begin
        if (!ov_r) begin
          on_nxt = to_io(rn_r);
          od_nxt = to_io(rd_r);
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      div_issued_r <= 1'b0;
      base_done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      div_issued_r <= div_issued_nxt;
      base_done_r <= base_done_nxt;
    end
    if (in_req.valid && in_req.ready) begin
      cmd_r <= in_req.command;
      an_r <= from_io(in_req.a_num);
      ad_r <= from_io(in_req.a_den);
      bn_r <= from_io(in_req.b_num);
      bd_r <= from_io(in_req.b_den);
      negexp_r <= in_req.exponent[EW-1];
      zz_r <= 1'b0;
    end else begin
      zz_r <= zz_nxt;
    end
    pw_r <= pw_nxt;
    rn_r <= rn_nxt; rd_r <= rd_nxt; rneg_r <= rneg_nxt;
    ga_r <= ga_nxt; gb_r <= gb_nxt; tmp_r <= tmp_nxt;
    basen_r <= basen_nxt; based_r <= based_nxt;
    on_r <= on_nxt; od_r <= od_nxt;
  end

  assign out_res.valid = ov_r;
  assign out_res.res_num = on_r;
  assign out_res.res_den = od_r;
  assign out_res.zero_by_zero = zz_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> state_r == S_IDLE && !ov_r) else $error("ready while busy");
  a_zz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && zz_r |-> on_r == '0 && od_r == '0) else $error("0/0 result not zero");
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> state_r != S_IDLE) else $error("accept did not start");
endmodule

/* hw/rtl/rau_divider.sv */
// Restoring radix-2 divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module rau_divider #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  q_r, q_nxt, d_r, d_nxt;
  logic [W:0]    rem_r, rem_nxt, trial;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt = q_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[W-1:0], q_r[W-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend;
      d_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[W]) begin
        rem_nxt = {rem_r[W-1:0], q_r[W-1]};
        q_nxt = {q_r[W-2:0], 1'b0};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    d_r <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
  assign remainder = rem_r[W-1:0];

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n) !busy_r && !start |=> cnt_r == $past(cnt_r))
    else $error("divider counter moved while idle");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0)
    else $error("divider busy with zero count");
endmodule
